// ----- rtl/hsl_pkg.sv -----
// ----------------------------------------------------------------------------
// hsl_pkg
// Shared types and constants of the RGB to HSL converter: field widths,
// pipeline depth, arithmetic constants and the front-end to divider bundle.
// ----------------------------------------------------------------------------
package hsl_pkg;

   // Field widths of the pixel and of the result.
   localparam int CHAN_W  = 8;
   localparam int HUE_W   = 9;
   localparam int PCT_W   = 7;

   // Restoring divider: one quotient bit per stage, quotients stay below 512.
   localparam int DIV_STAGES = 9;
   // Two front-end stages, the divider stages and the output register.
   localparam int NUM_STAGES = 2 + DIV_STAGES + 1;

   // Operand widths of the two divisions.
   localparam int HUE_NUM_W   = 18;
   localparam int HUE_DEN_W   = 9;
   localparam int SAT_NUM_W   = 16;
   localparam int SAT_DEN_W   = 9;

   // Lightness round(sm * 100 / 510) by reciprocal multiplication:
   // (sm * LIGHT_MUL + LIGHT_ADD) >> LIGHT_SHIFT, exact for every sm up to 510.
   localparam int LIGHT_PROD_W = 28;
   localparam int LIGHT_SHIFT  = 21;
   localparam int LIGHT_MUL    = 411220;
   localparam int LIGHT_ADD    = 1048611;

   // Arithmetic constants.
   localparam int HUE_STEP      = 60;
   localparam int HUE_GREEN_OFS = 120;
   localparam int HUE_BLUE_OFS  = 240;
   localparam int HUE_TURN      = 360;
   localparam int PCT_TWICE     = 200;
   localparam int SUM_HALF      = 255;
   localparam int SUM_FULL      = 510;

   // Channel that holds the maximum.
   typedef enum logic [1:0] {
      MAX_RED,
      MAX_GREEN,
      MAX_BLUE
   } max_sel_type;

   // Operands handed from the front end to the dividers.
   typedef struct packed {
      logic [HUE_NUM_W-1:0]   hue_num;
      logic [HUE_DEN_W-1:0]   hue_den;
      logic [SAT_NUM_W-1:0]   sat_num;
      logic [SAT_DEN_W-1:0]   sat_den;
      logic [PCT_W-1:0]       light;
      logic                   grey;
   } div_req_type;

endpackage

// ----- rtl/hsl_req_if.sv -----
// ----------------------------------------------------------------------------
// hsl_req_if
// Pixel channel: valid/ready handshake with red, green and blue payload.
// ----------------------------------------------------------------------------
interface hsl_req_if;
   import hsl_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAN_W-1:0] red;
   logic [CHAN_W-1:0] green;
   logic [CHAN_W-1:0] blue;

   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);

endinterface

// ----- rtl/hsl_rsp_if.sv -----
// ----------------------------------------------------------------------------
// hsl_rsp_if
// Result channel: valid/ready handshake with hue, saturation and lightness.
// ----------------------------------------------------------------------------
interface hsl_rsp_if;
   import hsl_pkg::*;

   logic             valid;
   logic             ready;
   logic [HUE_W-1:0] hue;
   logic [PCT_W-1:0] saturation;
   logic [PCT_W-1:0] lightness;

   modport source (output valid, output hue, output saturation, output lightness,
                   input ready);
   modport sink   (input valid, input hue, input saturation, input lightness,
                   output ready);

endinterface

// ----- rtl/rgb_to_hsl_converter.sv -----
// ----------------------------------------------------------------------------
// rgb_to_hsl_converter
// Converts an 8-bit RGB pixel to hue in degrees and HSL saturation and
// lightness in percent, each rounded half up, in a twelve-stage pipeline.
//
//   Channel  Dir  Handshake      Payload
//   req      in   valid/ready    red[7:0], green[7:0], blue[7:0]
//   rsp      out  valid/ready    hue[8:0], saturation[6:0], lightness[6:0]
//
// One pixel is accepted per cycle while rsp does not stall; a result passes
// two front-end stages, nine divider stages (one quotient bit each) and the
// output register. Lightness is finished in the front end and waits beside
// the dividers.
// Reset clears only the valid bits of the stages.
// A stall on rsp holds the output; each stage takes new data whenever it is
// empty or its successor moves, so bubbles close up and req stays ready
// until every stage holds a pixel and rsp stalls.
// ----------------------------------------------------------------------------
module rgb_to_hsl_converter
   import hsl_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   hsl_req_if.sink  req,
   hsl_rsp_if.source rsp
);

   logic [NUM_STAGES-1:0] valid_ff, valid_in;
   logic [NUM_STAGES-1:0] stage_en;
   logic [DIV_STAGES-1:0] grey_ff, grey_in;
   logic [PCT_W-1:0]      light_dly_ff [DIV_STAGES];
   logic [PCT_W-1:0]      light_dly_in [DIV_STAGES];

   div_req_type           div_req;
   logic [HUE_W-1:0]      hue_quo;
   logic [DIV_STAGES-1:0] sat_quo;

   logic [HUE_W-1:0]      hue_ff, hue_in;
   logic [PCT_W-1:0]      sat_ff, sat_in;
   logic [PCT_W-1:0]      light_ff, light_in;

   // A stage loads when it is empty or its content moves on.
   always_comb begin
      stage_en[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp.ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !valid_ff[k] || stage_en[k+1];
      end
   end

   // Valid bits travel with the data.
   always_comb begin
      valid_in = valid_ff;
      if (stage_en[0]) valid_in[0] = req.valid;
      for (int k = 1; k < NUM_STAGES; k++) begin
         if (stage_en[k]) valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Front end: extremes, then operands.
   hsl_front u_front (
      .clock    (clock),
      .stage_en (stage_en[1:0]),
      .red      (req.red),
      .green    (req.green),
      .blue     (req.blue),
      .div_req  (div_req)
   );

   // Two dividers run side by side with equal latency.
   hsl_divider #(.DW(HUE_NUM_W), .VW(HUE_DEN_W), .QW(DIV_STAGES)) u_hue_div (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES+1:2]),
      .dividend (div_req.hue_num),
      .divisor  (div_req.hue_den),
      .quotient (hue_quo)
   );

   hsl_divider #(.DW(SAT_NUM_W), .VW(SAT_DEN_W), .QW(DIV_STAGES)) u_sat_div (
      .clock    (clock),
      .stage_en (stage_en[DIV_STAGES+1:2]),
      .dividend (div_req.sat_num),
      .divisor  (div_req.sat_den),
      .quotient (sat_quo)
   );

   // The grey flag and the lightness follow the pixel through the divider stages.
   always_comb begin
      grey_in      = grey_ff;
      light_dly_in = light_dly_ff;
      if (stage_en[2]) begin
         grey_in[0]      = div_req.grey;
         light_dly_in[0] = div_req.light;
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         if (stage_en[k+2]) begin
            grey_in[k]      = grey_ff[k-1];
            light_dly_in[k] = light_dly_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      grey_ff      <= grey_in;
      light_dly_ff <= light_dly_in;
   end

   // Output register; a grey pixel has zero hue and saturation.
   always_comb begin
      hue_in   = grey_ff[DIV_STAGES-1] ? '0 : hue_quo;
      sat_in   = grey_ff[DIV_STAGES-1] ? '0 : sat_quo[PCT_W-1:0];
      light_in = light_dly_ff[DIV_STAGES-1];
   end

   always_ff @(posedge clock) begin
      if (stage_en[NUM_STAGES-1]) begin
         hue_ff   <= hue_in;
         sat_ff   <= sat_in;
         light_ff <= light_in;
      end
   end

   assign req.ready      = stage_en[0];
   assign rsp.valid      = valid_ff[NUM_STAGES-1];
   assign rsp.hue        = hue_ff;
   assign rsp.saturation = sat_ff;
   assign rsp.lightness  = light_ff;

   // Results stay within their ranges.
   a_hue_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.hue <= HUE_W'(HUE_TURN)))
      else $error("hue above a full turn");

   a_pct_range: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.saturation <= PCT_W'(100) && rsp.lightness <= PCT_W'(100)))
      else $error("saturation or lightness above 100 percent");

   // The input is held off only when every stage is occupied and the output stalls.
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> ((&valid_ff) && !rsp.ready))
      else $error("input held off while the pipeline has room");

   // A grey pixel leaving the dividers yields zero hue and saturation.
   a_grey_zero: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STAGES-2] && grey_ff[DIV_STAGES-1] && stage_en[NUM_STAGES-1])
      |=> (rsp.hue == '0 && rsp.saturation == '0))
      else $error("grey pixel with nonzero hue or saturation");

endmodule

// ----- rtl/hsl_front.sv -----
// ----------------------------------------------------------------------------
// hsl_front
// Two register stages: maximum and minimum search, then the hue and
// saturation operands for the dividers and the finished lightness.
// ----------------------------------------------------------------------------
module hsl_front
   import hsl_pkg::*;
(
   input  logic              clock,
   input  logic [1:0]        stage_en,
   input  logic [CHAN_W-1:0] red,
   input  logic [CHAN_W-1:0] green,
   input  logic [CHAN_W-1:0] blue,
   output div_req_type       div_req
);

   // Stage one registers.
   max_sel_type       sel_ff, sel_in;
   logic signed [8:0] diff_ff, diff_in;
   logic [7:0]        d_ff, d_in;
   logic [8:0]        sm_ff, sm_in;
   logic              grey_ff, grey_in;

   // Stage two register.
   div_req_type       req_ff, req_in;

   logic [7:0]         mx;
   logic [7:0]         mn;
   logic signed [18:0] num;
   logic signed [18:0] diff_ext;
   logic signed [18:0] d_ext;
   logic [7:0]         den;
   logic [9:0]         den_wide;
   logic [LIGHT_PROD_W-1:0] light_prod;

   // Maximum, minimum and the channel difference that feeds the hue.
   always_comb begin
      mx = red;
      if (green > mx) mx = green;
      if (blue > mx) mx = blue;
      mn = red;
      if (green < mn) mn = green;
      if (blue < mn) mn = blue;

      if (mx == red) begin
         sel_in  = MAX_RED;
         diff_in = $signed({1'b0, green}) - $signed({1'b0, blue});
      end else if (mx == green) begin
         sel_in  = MAX_GREEN;
         diff_in = $signed({1'b0, blue}) - $signed({1'b0, red});
      end else begin
         sel_in  = MAX_BLUE;
         diff_in = $signed({1'b0, red}) - $signed({1'b0, green});
      end
      d_in    = mx - mn;
      sm_in   = {1'b0, mx} + {1'b0, mn};
      grey_in = (mx == mn);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         sel_ff  <= sel_in;
         diff_ff <= diff_in;
         d_ff    <= d_in;
         sm_ff   <= sm_in;
         grey_ff <= grey_in;
      end
   end

   // Hue numerator with the sector offset, and the saturation denominator.
   always_comb begin
      diff_ext = 19'(diff_ff);
      d_ext    = $signed({11'b0, d_ff});
      num      = diff_ext * 19'(HUE_STEP);
      case (sel_ff)
         MAX_RED: begin
            if (diff_ff < 0) num = num + d_ext * 19'(HUE_TURN);
         end
         MAX_GREEN: num = num + d_ext * 19'(HUE_GREEN_OFS);
         MAX_BLUE:  num = num + d_ext * 19'(HUE_BLUE_OFS);
         default:   num = num;
      endcase

      den_wide = 10'(SUM_FULL) - {1'b0, sm_ff};
      den      = (sm_ff < 9'(SUM_HALF)) ? sm_ff[7:0] : den_wide[7:0];

      // Lightness needs no divider: a reciprocal product with the rounding
      // term folded into the added constant.
      light_prod = LIGHT_PROD_W'(sm_ff) * LIGHT_PROD_W'(LIGHT_MUL)
                 + LIGHT_PROD_W'(LIGHT_ADD);

      // Rounding half up: floor((2p + q) / 2q).
      req_in.hue_num   = HUE_NUM_W'({num[17:0], 1'b0}) + HUE_NUM_W'(d_ff);
      req_in.hue_den   = {d_ff, 1'b0};
      req_in.sat_num   = SAT_NUM_W'(d_ff) * SAT_NUM_W'(PCT_TWICE) + SAT_NUM_W'(den);
      req_in.sat_den   = {den, 1'b0};
      req_in.light     = light_prod[LIGHT_SHIFT +: PCT_W];
      req_in.grey      = grey_ff;
   end

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         req_ff <= req_in;
      end
   end

   assign div_req = req_ff;

endmodule

// ----- rtl/hsl_divider.sv -----
// ----------------------------------------------------------------------------
// hsl_divider
// Pipelined restoring divider: one quotient bit per register stage, most
// significant bit first. The quotient must fit in QW bits.
// ----------------------------------------------------------------------------
module hsl_divider #(
   parameter int DW = 18,
   parameter int VW = 9,
   parameter int QW = 9
) (
   input  logic          clock,
   input  logic [QW-1:0] stage_en,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic [QW-1:0] quotient
);

   localparam int WW = (DW > VW + QW - 1) ? DW : VW + QW - 1;

   logic [WW-1:0] rem_ff [QW-1];
   logic [VW-1:0] div_ff [QW-1];
   logic [QW-1:0] quo_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [WW-1:0] rem_prev;
      logic [WW-1:0] trial;
      logic [VW-1:0] div_prev;
      logic [QW-1:0] quo_prev;
      logic          fits;

      // Operands from the previous stage, or from the ports at the first one.
      if (k == 0) begin : g_first
         assign rem_prev = WW'(dividend);
         assign div_prev = divisor;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign div_prev = div_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      // Trial subtraction of the shifted divisor decides this quotient bit.
      assign trial = WW'(div_prev) << (QW - 1 - k);
      assign fits  = (rem_prev >= trial);

      always_ff @(posedge clock) begin
         if (stage_en[k]) begin
            quo_ff[k] <= {quo_prev[QW-2:0], fits};
         end
      end

      if (k < QW - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (stage_en[k]) begin
               rem_ff[k] <= fits ? (rem_prev - trial) : rem_prev;
               div_ff[k] <= div_prev;
            end
         end
      end
   end

   assign quotient = quo_ff[QW-1];

endmodule
